FILE: hw/rtl/hsagc_pkg.sv
// Shared types, constants and defaults of the histogram saturation AGC.
`timescale 1ns / 1ps
package hsagc_pkg;

   localparam int HIST_BINS_DEF    = 64;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int MAX_BLOCK_DEF    = 4096;
   localparam int RATIO_WINDOW_DEF = 5;
   localparam int GAIN_WINDOW_DEF  = 10;

   localparam int GAIN_W     = 7;
   localparam int RATIO_W    = 17;
   localparam int STEP_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int Q16_SHIFT  = 16;
   localparam int GAIN_MAX   = 127;

   localparam logic [GAIN_W-1:0]  GAIN_SWITCH_RST = 7'd32;
   localparam logic [RATIO_W-1:0] RATIO_LIMIT_RST = 17'd1966;
   localparam logic [STEP_W-1:0]  GAIN_STEP_RST   = 5'd2;

   localparam int PCT_SAT_HI  = 90;
   localparam int PCT_HIGH_HI = 25;
   localparam int PCT_SAT_LO  = 85;
   localparam int PCT_HIGH_LO = 55;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_SWITCH = 2'd0,
      CSR_RATIO_LIMIT = 2'd1,
      CSR_GAIN_STEP   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_HOLD = 2'd0,
      ACT_DEC  = 2'd1,
      ACT_INC  = 2'd2
   } gain_action_type;

   typedef struct packed {
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
      logic               last_sample;
      logic [GAIN_W-1:0]  current_gain_db;
   } req_payload_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  new_gain_db;
      logic [1:0]         gain_action;
      logic [RATIO_W-1:0] sat_ratio_q16;
      logic [RATIO_W-1:0] high_energy_ratio_q16;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
   } bin_status_type;

   typedef struct packed {
      logic done;
   } div_status_type;

endpackage

FILE: hw/rtl/hsagc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hsagc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read before write: a read of the entry being written returns the old word.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/hsagc_binner.sv
// Sample path: magnitude squared, bin search and histogram increment.
`timescale 1ns / 1ps
module hsagc_binner import hsagc_pkg::*; #(
   parameter int HIST_BINS   = HIST_BINS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
   localparam int BIN_W = $clog2(HIST_BINS),
   localparam int CNT_W = $clog2(MAX_BLOCK + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  req_payload_type  sample,
   input  logic             clear_count,
   output logic [CNT_W-1:0] sample_count,
   output logic [BIN_W-1:0] rd_addr,
   input  logic [CNT_W-1:0] rd_data,
   output logic             wr_en,
   output logic [BIN_W-1:0] wr_addr,
   output logic [CNT_W-1:0] wr_data,
   output bin_status_type   status
);

   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int MAG_W = SQ_W + 1;
   localparam longint unsigned S2  = 64'd1 << (2 * SAMPLE_BITS - 2);
   localparam longint unsigned HB2 = longint'(HIST_BINS) * HIST_BINS;

   logic signed [31:0]     re_ext, im_ext;
   logic [SAMPLE_BITS-1:0] raw_re, raw_im, abs_re, abs_im;
   logic [SQ_W-1:0]        sq_re, sq_im;
   logic [SQ_W-1:0]        sq_re_ff, sq_im_ff, sq_re_in, sq_im_in;
   logic                   s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [MAG_W-1:0]       mag2;
   logic [HIST_BINS-1:1]   ge;
   logic [BIN_W-1:0]       bin;
   logic [BIN_W-1:0]       bin_s2_ff, bin_s2_in;
   logic                   lw_valid_ff, lw_valid_in;
   logic [BIN_W-1:0]       lw_addr_ff, lw_addr_in;
   logic [CNT_W-1:0]       lw_data_ff, lw_data_in;
   logic [CNT_W-1:0]       cur_count;
   logic                   below_max;

   assign re_ext = 32'(sample.sample_re);
   assign im_ext = 32'(sample.sample_im);
   assign raw_re = re_ext[SAMPLE_BITS-1:0];
   assign raw_im = im_ext[SAMPLE_BITS-1:0];
   // The most negative code maps to 2^(SAMPLE_BITS-1), which still fits unsigned.
   assign abs_re = raw_re[SAMPLE_BITS-1] ? (~raw_re + 1'b1) : raw_re;
   assign abs_im = raw_im[SAMPLE_BITS-1] ? (~raw_im + 1'b1) : raw_im;
   assign sq_re  = abs_re * abs_re;
   assign sq_im  = abs_im * abs_im;

   assign below_max = count_ff < CNT_W'(MAX_BLOCK);
   assign mag2      = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};

   // Bin i starts where mag2 * BINS^2 reaches i^2 * full scale squared.
   for (genvar gi = 1; gi < HIST_BINS; gi++) begin : g_thr
      localparam longint unsigned TH = (longint'(gi) * gi * S2 + HB2 - 1) / HB2;
      assign ge[gi] = mag2 >= MAG_W'(TH);
   end

   always_comb begin
      bin = '0;
      for (int i = 1; i < HIST_BINS; i++) begin
         if (ge[i]) begin
            bin = BIN_W'(i);
         end
      end
   end

   // The previous increment is not yet visible in the read data.
   assign cur_count = (lw_valid_ff && lw_addr_ff == bin_s2_ff) ? lw_data_ff : rd_data;

   always_comb begin
      sq_re_in    = sq_re;
      sq_im_in    = sq_im;
      s1_valid_in = accept && below_max;
      s2_valid_in = s1_valid_ff;
      bin_s2_in   = bin;
      lw_valid_in = s2_valid_ff;
      lw_addr_in  = bin_s2_ff;
      lw_data_in  = cur_count + 1'b1;
      count_in    = count_ff;
      if (clear_count) begin
         count_in = '0;
      end else if (accept && below_max) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sq_re_ff   <= sq_re_in;
      sq_im_ff   <= sq_im_in;
      bin_s2_ff  <= bin_s2_in;
      lw_addr_ff <= lw_addr_in;
      lw_data_ff <= lw_data_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         lw_valid_ff <= lw_valid_in;
         count_ff    <= count_in;
      end
   end

   assign rd_addr      = bin;
   assign wr_en        = s2_valid_ff;
   assign wr_addr      = bin_s2_ff;
   assign wr_data      = lw_data_in;
   assign sample_count = count_ff;
   assign status.busy  = s1_valid_ff | s2_valid_ff;

endmodule

FILE: hw/rtl/hsagc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module hsagc_div import hsagc_pkg::*; #(
   parameter int NUM_W = 29,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quotient,
   output div_status_type   status
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [DEN_W:0]   rem_ff, rem_in, shifted;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic             fits;

   assign shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         den_in = den;
         cnt_in = CW'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? (shifted - {1'b0, den_ff}) : shifted;
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.done = done_ff;

endmodule

FILE: hw/rtl/hsagc_ctrl.sv
// Block-end sequencer: histogram sweep, tail ratios, windows and gain decision.
`timescale 1ns / 1ps
module hsagc_ctrl import hsagc_pkg::*; #(
   parameter int HIST_BINS    = HIST_BINS_DEF,
   parameter int MAX_BLOCK    = MAX_BLOCK_DEF,
   parameter int RATIO_WINDOW = RATIO_WINDOW_DEF,
   parameter int GAIN_WINDOW  = GAIN_WINDOW_DEF,
   localparam int BIN_W = $clog2(HIST_BINS),
   localparam int CNT_W = $clog2(MAX_BLOCK + 1),
   localparam int NUM_W = CNT_W + Q16_SHIFT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_accept,
   input  req_payload_type       req_payload,
   output logic                  req_stall,
   input  bin_status_type        bin_status,
   input  logic [CNT_W-1:0]      sample_count,
   output logic                  clear_count,
   output logic                  sweep_sel,
   output logic [BIN_W-1:0]      sweep_addr,
   input  logic [CNT_W-1:0]      hist_data,
   output logic                  div_start,
   output logic [NUM_W-1:0]      div_num,
   output logic [CNT_W-1:0]      div_den,
   input  logic [NUM_W-1:0]      div_quo,
   input  div_status_type        div_status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload
);

   localparam int RP_W = (RATIO_WINDOW > 1) ? $clog2(RATIO_WINDOW) : 1;
   localparam int RF_W = $clog2(RATIO_WINDOW + 1);
   localparam int RS_W = RATIO_W + RF_W;
   localparam int GP_W = (GAIN_WINDOW > 1) ? $clog2(GAIN_WINDOW) : 1;
   localparam int GF_W = $clog2(GAIN_WINDOW + 1);
   localparam int GS_W = GAIN_W + GF_W;
   localparam int T_SAT_HI  = ((HIST_BINS - 1) * PCT_SAT_HI) / 100;
   localparam int T_HIGH_HI = ((HIST_BINS - 1) * PCT_HIGH_HI) / 100;
   localparam int T_SAT_LO  = ((HIST_BINS - 1) * PCT_SAT_LO) / 100;
   localparam int T_HIGH_LO = ((HIST_BINS - 1) * PCT_HIGH_LO) / 100;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DRAIN, ST_SWEEP, ST_SWTAIL, ST_DIVU, ST_WAITU,
      ST_DIVL, ST_WAITL, ST_UPDATE, ST_DIVG, ST_WAITG, ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [GAIN_W-1:0]  gain_switch_ff, gain_switch_in;
   logic [RATIO_W-1:0] limit_ff, limit_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [GAIN_W-1:0]  cur_gain_ff, cur_gain_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [BIN_W-1:0]   k_ff, k_in, kd_ff, kd_in;
   logic               dv_ff, dv_in;
   logic [CNT_W-1:0]   cnt_u_ff, cnt_u_in, cnt_l_ff, cnt_l_in;
   logic [RATIO_W-1:0] sat_ff, sat_in, high_ff, high_in;
   logic [RP_W-1:0]    rpos_ff, rpos_in;
   logic [RF_W-1:0]    rfill_ff, rfill_in;
   logic [RS_W-1:0]    ssum_ff, ssum_in, hsum_ff, hsum_in;
   logic [GP_W-1:0]    gpos_ff, gpos_in;
   logic [GF_W-1:0]    gfill_ff, gfill_in;
   logic [GS_W-1:0]    gsum_ff, gsum_in;
   logic [1:0]         action_ff, action_in;
   logic [GAIN_W-1:0]  newg_ff, newg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic                 hi_gain;
   logic [BIN_W-1:0]     t_upper, t_lower;
   logic [2*RATIO_W-1:0] rold;
   logic [GAIN_W-1:0]    gold, gclamp;
   logic                 rfull, gfull, dec, inc, win_we;
   logic [RF_W-1:0]      rfill_new;
   logic [GF_W-1:0]      gfill_new;
   logic [RS_W-1:0]      ssum_new, hsum_new, lim;
   logic [GS_W-1:0]      gsum_new;
   logic signed [9:0]    gstep;

   assign hi_gain = cur_gain_ff >= gain_switch_ff;
   assign t_upper = hi_gain ? BIN_W'(T_SAT_HI) : BIN_W'(T_SAT_LO);
   assign t_lower = hi_gain ? BIN_W'(T_HIGH_HI) : BIN_W'(T_HIGH_LO);

   // Window entries are read only once the window is full, so never before a write.
   hsagc_ram #(.WIDTH(2 * RATIO_W), .DEPTH(RATIO_WINDOW)) u_ratio_win (
      .clock (clock),
      .we    (win_we),
      .waddr (rpos_ff),
      .wdata ({sat_ff, high_ff}),
      .raddr (rpos_ff),
      .rdata (rold)
   );

   hsagc_ram #(.WIDTH(GAIN_W), .DEPTH(GAIN_WINDOW)) u_gain_win (
      .clock (clock),
      .we    (win_we),
      .waddr (gpos_ff),
      .wdata (gclamp),
      .raddr (gpos_ff),
      .rdata (gold)
   );

   assign win_we    = state_ff == ST_UPDATE;
   assign rfull     = rfill_ff == RF_W'(RATIO_WINDOW);
   assign gfull     = gfill_ff == GF_W'(GAIN_WINDOW);
   assign rfill_new = rfull ? rfill_ff : rfill_ff + 1'b1;
   assign gfill_new = gfull ? gfill_ff : gfill_ff + 1'b1;
   assign ssum_new  = ssum_ff + RS_W'(sat_ff)
                      - (rfull ? RS_W'(rold[2*RATIO_W-1:RATIO_W]) : RS_W'(0));
   assign hsum_new  = hsum_ff + RS_W'(high_ff)
                      - (rfull ? RS_W'(rold[RATIO_W-1:0]) : RS_W'(0));
   assign lim       = RS_W'(limit_ff) * RS_W'(rfill_new);
   assign dec       = ssum_new > lim;
   assign inc       = !dec && (hsum_new < lim);

   always_comb begin
      gstep = $signed({3'b000, cur_gain_ff});
      if (dec) begin
         gstep = gstep - $signed({5'b00000, step_ff});
      end else if (inc) begin
         gstep = gstep + $signed({5'b00000, step_ff});
      end
      if (gstep < 0) begin
         gclamp = '0;
      end else if (gstep > GAIN_MAX) begin
         gclamp = GAIN_W'(GAIN_MAX);
      end else begin
         gclamp = gstep[GAIN_W-1:0];
      end
   end

   assign gsum_new = gsum_ff + GS_W'(gclamp) - (gfull ? GS_W'(gold) : GS_W'(0));

   always_comb begin
      state_in       = state_ff;
      gain_switch_in = gain_switch_ff;
      limit_in       = limit_ff;
      step_in        = step_ff;
      cur_gain_in    = cur_gain_ff;
      total_in       = total_ff;
      k_in           = k_ff;
      kd_in          = k_ff;
      dv_in          = 1'b0;
      cnt_u_in       = cnt_u_ff;
      cnt_l_in       = cnt_l_ff;
      sat_in         = sat_ff;
      high_in        = high_ff;
      rpos_in        = rpos_ff;
      rfill_in       = rfill_ff;
      ssum_in        = ssum_ff;
      hsum_in        = hsum_ff;
      gpos_in        = gpos_ff;
      gfill_in       = gfill_ff;
      gsum_in        = gsum_ff;
      action_in      = action_ff;
      newg_in        = newg_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      clear_count    = 1'b0;
      div_start      = 1'b0;
      div_num        = {cnt_u_ff, Q16_SHIFT'(0)};
      div_den        = total_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_GAIN_SWITCH: gain_switch_in = csr_wdata[GAIN_W-1:0];
            CSR_RATIO_LIMIT: limit_in = csr_wdata[RATIO_W-1:0];
            CSR_GAIN_STEP:   step_in = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end

      // Sweep data arrives in the cycle after its address.
      if (dv_ff) begin
         if (kd_ff > t_upper) begin
            cnt_u_in = cnt_u_ff + hist_data;
         end
         if (kd_ff > t_lower) begin
            cnt_l_in = cnt_l_ff + hist_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_payload.last_sample) begin
               cur_gain_in = req_payload.current_gain_db;
               state_in    = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!bin_status.busy) begin
               clear_count = 1'b1;
               total_in    = sample_count;
               cnt_u_in    = '0;
               cnt_l_in    = '0;
               k_in        = '0;
               state_in    = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            dv_in = 1'b1;
            k_in  = k_ff + 1'b1;
            if (k_ff == BIN_W'(HIST_BINS - 1)) begin
               state_in = ST_SWTAIL;
            end
         end
         ST_SWTAIL: state_in = ST_DIVU;
         ST_DIVU: begin
            div_start = 1'b1;
            state_in  = ST_WAITU;
         end
         ST_WAITU: begin
            if (div_status.done) begin
               sat_in   = (total_ff == '0) ? '0 : div_quo[RATIO_W-1:0];
               state_in = ST_DIVL;
            end
         end
         ST_DIVL: begin
            div_start = 1'b1;
            div_num   = {cnt_l_ff, Q16_SHIFT'(0)};
            state_in  = ST_WAITL;
         end
         ST_WAITL: begin
            if (div_status.done) begin
               high_in  = (total_ff == '0) ? '0 : div_quo[RATIO_W-1:0];
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ssum_in  = ssum_new;
            hsum_in  = hsum_new;
            rfill_in = rfill_new;
            rpos_in  = (rpos_ff == RP_W'(RATIO_WINDOW - 1)) ? '0 : rpos_ff + 1'b1;
            gsum_in  = gsum_new;
            gfill_in = gfill_new;
            gpos_in  = (gpos_ff == GP_W'(GAIN_WINDOW - 1)) ? '0 : gpos_ff + 1'b1;
            if (dec) begin
               action_in = ACT_DEC;
               state_in  = ST_DIVG;
            end else if (inc) begin
               action_in = ACT_INC;
               state_in  = ST_DIVG;
            end else begin
               action_in = ACT_HOLD;
               newg_in   = cur_gain_ff;
               state_in  = ST_EMIT;
            end
         end
         ST_DIVG: begin
            div_start = 1'b1;
            div_num   = NUM_W'(gsum_ff);
            div_den   = CNT_W'(gfill_ff);
            state_in  = ST_WAITG;
         end
         ST_WAITG: begin
            if (div_status.done) begin
               newg_in  = div_quo[GAIN_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_in.new_gain_db           = newg_ff;
               rsp_in.gain_action           = action_ff;
               rsp_in.sat_ratio_q16         = sat_ff;
               rsp_in.high_energy_ratio_q16 = high_ff;
               state_in                     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      k_ff     <= k_in;
      kd_ff    <= kd_in;
      cnt_u_ff <= cnt_u_in;
      cnt_l_ff <= cnt_l_in;
      sat_ff   <= sat_in;
      high_ff  <= high_in;
      cur_gain_ff <= cur_gain_in;
      action_ff   <= action_in;
      newg_ff     <= newg_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         gain_switch_ff <= GAIN_SWITCH_RST;
         limit_ff       <= RATIO_LIMIT_RST;
         step_ff        <= GAIN_STEP_RST;
         dv_ff          <= 1'b0;
         rpos_ff        <= '0;
         rfill_ff       <= '0;
         ssum_ff        <= '0;
         hsum_ff        <= '0;
         gpos_ff        <= '0;
         gfill_ff       <= '0;
         gsum_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         gain_switch_ff <= gain_switch_in;
         limit_ff       <= limit_in;
         step_ff        <= step_in;
         dv_ff          <= dv_in;
         rpos_ff        <= rpos_in;
         rfill_ff       <= rfill_in;
         ssum_ff        <= ssum_in;
         hsum_ff        <= hsum_in;
         gpos_ff        <= gpos_in;
         gfill_ff       <= gfill_in;
         gsum_ff        <= gsum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign sweep_sel   = state_ff == ST_SWEEP;
   assign sweep_addr  = k_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hw/rtl/histogram_saturation_agc_unit.sv
// Within a block one sample beat is taken per cycle; the result follows the last beat
// once the histogram sweep and the bit-serial divider, used up to three times, are done.
// Throughput: req is stalled from the last beat of a block until its result is issued.
// Reset: synchronous; histogram entries read as zero through per-bin valid bits,
// windows empty, registers at their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
module histogram_saturation_agc_unit import hsagc_pkg::*; #(
   parameter int HIST_BINS    = HIST_BINS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int MAX_BLOCK    = MAX_BLOCK_DEF,
   parameter int RATIO_WINDOW = RATIO_WINDOW_DEF,
   parameter int GAIN_WINDOW  = GAIN_WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int BIN_W = $clog2(HIST_BINS);
   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam int NUM_W = CNT_W + Q16_SHIFT;

   logic                 req_accept, clear_count, sweep_sel;
   logic [CNT_W-1:0]     sample_count, hist_data, ram_q, bin_wr_data, ram_wdata;
   logic [BIN_W-1:0]     bin_rd_addr, bin_wr_addr, sweep_addr, ram_waddr, ram_raddr;
   logic                 bin_wr_en, ram_we;
   bin_status_type       bin_status;
   div_status_type       div_status;
   logic                 div_start;
   logic [NUM_W-1:0]     div_num, div_quo;
   logic [CNT_W-1:0]     div_den;
   logic [HIST_BINS-1:0] hv_ff, hv_in;
   logic                 rv_ff, rv_in;

   assign req_accept = req_valid && !req_stall;

   hsagc_binner #(
      .HIST_BINS(HIST_BINS), .SAMPLE_BITS(SAMPLE_BITS), .MAX_BLOCK(MAX_BLOCK)
   ) u_binner (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .sample       (req_payload),
      .clear_count  (clear_count),
      .sample_count (sample_count),
      .rd_addr      (bin_rd_addr),
      .rd_data      (hist_data),
      .wr_en        (bin_wr_en),
      .wr_addr      (bin_wr_addr),
      .wr_data      (bin_wr_data),
      .status       (bin_status)
   );

   // The sweep reads each bin and writes zero in its place in the same cycle.
   assign ram_we    = sweep_sel | bin_wr_en;
   assign ram_waddr = sweep_sel ? sweep_addr : bin_wr_addr;
   assign ram_wdata = sweep_sel ? '0 : bin_wr_data;
   assign ram_raddr = sweep_sel ? sweep_addr : bin_rd_addr;

   hsagc_ram #(.WIDTH(CNT_W), .DEPTH(HIST_BINS)) u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   always_comb begin
      hv_in = hv_ff;
      if (ram_we) begin
         hv_in[ram_waddr] = 1'b1;
      end
      rv_in = hv_ff[ram_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         hv_ff <= hv_in;
         rv_ff <= rv_in;
      end
   end

   assign hist_data = rv_ff ? ram_q : '0;

   hsagc_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .quotient (div_quo),
      .status   (div_status)
   );

   hsagc_ctrl #(
      .HIST_BINS(HIST_BINS), .MAX_BLOCK(MAX_BLOCK),
      .RATIO_WINDOW(RATIO_WINDOW), .GAIN_WINDOW(GAIN_WINDOW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_accept   (req_accept),
      .req_payload  (req_payload),
      .req_stall    (req_stall),
      .bin_status   (bin_status),
      .sample_count (sample_count),
      .clear_count  (clear_count),
      .sweep_sel    (sweep_sel),
      .sweep_addr   (sweep_addr),
      .hist_data    (hist_data),
      .div_start    (div_start),
      .div_num      (div_num),
      .div_den      (div_den),
      .div_quo      (div_quo),
      .div_status   (div_status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

`ifndef ASSERT_OFF
   // The sweep owns the histogram only after the sample pipeline has drained.
   a_sweep_excl: assert property (@(posedge clock) disable iff (reset)
      !(sweep_sel && bin_wr_en))
      else $error("histogram sweep overlaps a sample increment");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.gain_action == ACT_HOLD ||
                     rsp_payload.gain_action == ACT_DEC ||
                     rsp_payload.gain_action == ACT_INC))
      else $error("result carries an undefined gain action");

   // A new result beat is only issued while the input side is held off.
   a_rsp_after_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result issued outside the block-end sequence");

   a_no_sample_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_sel |-> req_stall)
      else $error("sample accepted during histogram sweep");
`endif

endmodule
